// ----- hw/rtl/u4b_enc_pkg.sv -----
package u4b_enc_pkg;

	// configuration register indexes
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CfgFirstChar = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgThirdChar = 2'd1;
	localparam logic [7:0] ChanCharReset = 8'd48;

	// field limits
	localparam logic [10:0] AltMax = 11'd1067;
	localparam logic [10:0] AltCodes = 11'd1068;
	localparam logic signed [14:0] TempMinTenths = -15'sd500;
	localparam logic signed [14:0] TempMaxTenths = 15'sd390;
	localparam logic [13:0] VoltMin = 14'd300;
	localparam logic [13:0] VoltMax = 14'd495;
	localparam logic [5:0] SpeedMax = 6'd41;

	// ascii bases
	localparam logic [7:0] AsciiA = 8'd65;
	localparam logic [7:0] AsciiX = 8'd88;
	localparam logic [6:0] LetterBase = 7'd65;
	localparam logic [6:0] DigitBase7 = 7'd48;
	localparam logic [5:0] DigitBase6 = 6'd48;

	// small reciprocals, exact over the clamped ranges
	localparam logic [15:0] Div5Alt = 16'd52429;  // x * m >> 18, x < 2^18
	localparam logic [7:0] Div10Temp = 8'd205;   // a * m >> 11, a <= 500
	localparam logic [7:0] Div5Volt = 8'd205;    // n * m >> 10, n <= 197

	// reciprocals for 20-bit numerators: m = ceil(2^k / d), k = 20 + ceil(log2 d)
	localparam int RecipW = 22;
	localparam int ProdW = 42;
	localparam int ShV1 = 25;
	localparam int ShV2 = 30;
	localparam int ShV3 = 35;
	localparam int ShW1 = 25;
	localparam int ShW2 = 28;
	localparam int ShW3 = 31;
	localparam int ShW4 = 36;
	localparam logic [RecipW-1:0] MulV1 = RecipW'(((64'd1 << ShV1) + 64'd25) / 64'd26);
	localparam logic [RecipW-1:0] MulV2 = RecipW'(((64'd1 << ShV2) + 64'd675) / 64'd676);
	localparam logic [RecipW-1:0] MulV3 = RecipW'(((64'd1 << ShV3) + 64'd17575) / 64'd17576);
	localparam logic [RecipW-1:0] MulW1 = RecipW'(((64'd1 << ShW1) + 64'd18) / 64'd19);
	localparam logic [RecipW-1:0] MulW2 = RecipW'(((64'd1 << ShW2) + 64'd189) / 64'd190);
	localparam logic [RecipW-1:0] MulW3 = RecipW'(((64'd1 << ShW3) + 64'd1899) / 64'd1900);
	localparam logic [RecipW-1:0] MulW4 = RecipW'(((64'd1 << ShW4) + 64'd34199) / 64'd34200);

	// one snapshot as taken from the input channel
	typedef struct packed {
		logic [7:0]         subsquare_letter_a;
		logic [7:0]         subsquare_letter_b;
		logic [19:0]        altitude_meters;
		logic signed [14:0] temp_tenths;
		logic [13:0]        volt_hundredths;
		logic [9:0]         speed_knots;
	} raw_t;

	// clamped field codes
	typedef struct packed {
		logic [4:0]  g5;
		logic [4:0]  g6;
		logic [10:0] alt_code;
		logic [6:0]  tcode;
		logic [5:0]  vcode;
		logic [5:0]  scode;
	} codes_t;

	// the two mixed-radix words
	typedef struct packed {
		logic [19:0] val;
		logic [19:0] w;
	} pack_t;

	// quotients of both words by the running radix products
	typedef struct packed {
		logic [19:0] val;
		logic [19:0] w;
		logic [14:0] vq1;
		logic [9:0]  vq2;
		logic [5:0]  vq3;
		logic [14:0] wq1;
		logic [11:0] wq2;
		logic [8:0]  wq3;
		logic [4:0]  wq4;
	} quot_t;

	// computed message characters
	typedef struct packed {
		logic [6:0] call_char_2;
		logic [6:0] call_char_4;
		logic [6:0] call_char_5;
		logic [6:0] call_char_6;
		logic [6:0] grid_char_1;
		logic [6:0] grid_char_2;
		logic [5:0] grid_char_3;
		logic [5:0] grid_char_4;
		logic [5:0] power_dbm;
	} digits_t;

	// legal power levels in dbm
	function automatic logic [5:0] power_level(input logic [4:0] idx);
		logic [5:0] p;
		case (idx)
			5'd0:  p = 6'd0;
			5'd1:  p = 6'd3;
			5'd2:  p = 6'd7;
			5'd3:  p = 6'd10;
			5'd4:  p = 6'd13;
			5'd5:  p = 6'd17;
			5'd6:  p = 6'd20;
			5'd7:  p = 6'd23;
			5'd8:  p = 6'd27;
			5'd9:  p = 6'd30;
			5'd10: p = 6'd33;
			5'd11: p = 6'd37;
			5'd12: p = 6'd40;
			5'd13: p = 6'd43;
			5'd14: p = 6'd47;
			5'd15: p = 6'd50;
			5'd16: p = 6'd53;
			5'd17: p = 6'd57;
			5'd18: p = 6'd60;
			default: p = 6'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/u4b_enc_if.sv -----
// snapshot channel
interface u4b_enc_snap_if;
	logic               valid;
	logic               ready;
	logic [7:0]         subsquare_letter_a;
	logic [7:0]         subsquare_letter_b;
	logic [19:0]        altitude_meters;
	logic signed [14:0] temp_tenths;
	logic [13:0]        volt_hundredths;
	logic [9:0]         speed_knots;

	modport source (
		output valid, subsquare_letter_a, subsquare_letter_b, altitude_meters,
		output temp_tenths, volt_hundredths, speed_knots,
		input ready
	);
	modport sink (
		input valid, subsquare_letter_a, subsquare_letter_b, altitude_meters,
		input temp_tenths, volt_hundredths, speed_knots,
		output ready
	);
endinterface

// message channel
interface u4b_enc_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] call_char_1;
	logic [6:0] call_char_2;
	logic [7:0] call_char_3;
	logic [6:0] call_char_4;
	logic [6:0] call_char_5;
	logic [6:0] call_char_6;
	logic [6:0] grid_char_1;
	logic [6:0] grid_char_2;
	logic [5:0] grid_char_3;
	logic [5:0] grid_char_4;
	logic [5:0] power_dbm;

	modport source (
		output valid, call_char_1, call_char_2, call_char_3, call_char_4,
		output call_char_5, call_char_6, grid_char_1, grid_char_2,
		output grid_char_3, grid_char_4, power_dbm,
		input ready
	);
	modport sink (
		input valid, call_char_1, call_char_2, call_char_3, call_char_4,
		input call_char_5, call_char_6, grid_char_1, grid_char_2,
		input grid_char_3, grid_char_4, power_dbm,
		output ready
	);
endinterface

// configuration write channel
interface u4b_enc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [u4b_enc_pkg::CfgIdxW-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/u4b_enc_codes.sv -----
module u4b_enc_codes (
	input  u4b_enc_pkg::raw_t   raw,
	output u4b_enc_pkg::codes_t codes
);

	logic [17:0]        alt_quarter;
	logic [33:0]        alt_prod;
	logic [15:0]        alt_div;
	logic signed [14:0] t_clamp;
	logic               t_neg;
	logic [8:0]         t_abs;
	logic [16:0]        t_prod;
	logic [5:0]         t_deg;
	logic [13:0]        v_clamp;
	logic [7:0]         v_off;
	logic [15:0]        v_prod;
	logic [5:0]         v_step;
	logic [5:0]         v_sum;
	logic [9:0]         s_half;
	logic [10:0]        s_inc;

	// subsquare letters, bad letter counts as A
	always_comb begin
		if (raw.subsquare_letter_a inside {[u4b_enc_pkg::AsciiA:u4b_enc_pkg::AsciiX]}) begin
			codes.g5 = 5'(raw.subsquare_letter_a - u4b_enc_pkg::AsciiA);
		end else begin
			codes.g5 = '0;
		end
		if (raw.subsquare_letter_b inside {[u4b_enc_pkg::AsciiA:u4b_enc_pkg::AsciiX]}) begin
			codes.g6 = 5'(raw.subsquare_letter_b - u4b_enc_pkg::AsciiA);
		end else begin
			codes.g6 = '0;
		end
	end

	// altitude / 20 as (alt >> 2) / 5, saturated
	assign alt_quarter = raw.altitude_meters[19:2];
	assign alt_prod = 34'(alt_quarter) * 34'(u4b_enc_pkg::Div5Alt);
	assign alt_div = alt_prod[33:18];
	assign codes.alt_code = (alt_div > 16'(u4b_enc_pkg::AltMax)) ?
		u4b_enc_pkg::AltMax : alt_div[10:0];

	// temperature clamp and whole degrees toward zero
	always_comb begin
		if (raw.temp_tenths < u4b_enc_pkg::TempMinTenths) begin
			t_clamp = u4b_enc_pkg::TempMinTenths;
		end else if (raw.temp_tenths > u4b_enc_pkg::TempMaxTenths) begin
			t_clamp = u4b_enc_pkg::TempMaxTenths;
		end else begin
			t_clamp = raw.temp_tenths;
		end
	end
	assign t_neg = t_clamp[14];
	assign t_abs = t_neg ? 9'(-t_clamp) : 9'(t_clamp);
	assign t_prod = 17'(t_abs) * 17'(u4b_enc_pkg::Div10Temp);
	assign t_deg = t_prod[16:11];
	assign codes.tcode = t_neg ? (7'd50 - 7'(t_deg)) : (7'd50 + 7'(t_deg));

	// voltage clamp, rounded 50 mV steps, offset 20 modulo 40
	always_comb begin
		if (raw.volt_hundredths > u4b_enc_pkg::VoltMax) begin
			v_clamp = u4b_enc_pkg::VoltMax;
		end else if (raw.volt_hundredths < u4b_enc_pkg::VoltMin) begin
			v_clamp = u4b_enc_pkg::VoltMin;
		end else begin
			v_clamp = raw.volt_hundredths;
		end
	end
	assign v_off = 8'(v_clamp - u4b_enc_pkg::VoltMin + 14'd2);
	assign v_prod = 16'(v_off) * 16'(u4b_enc_pkg::Div5Volt);
	assign v_step = v_prod[15:10];
	assign v_sum = v_step + 6'd20;
	assign codes.vcode = (v_sum >= 6'd40) ? (v_sum - 6'd40) : v_sum;

	// speed code, saturated
	assign s_inc = {1'b0, raw.speed_knots} + 11'd1;
	assign s_half = s_inc[10:1];
	assign codes.scode = (s_half > 10'(u4b_enc_pkg::SpeedMax)) ?
		u4b_enc_pkg::SpeedMax : s_half[5:0];

endmodule

// ----- hw/rtl/u4b_enc_pack.sv -----
module u4b_enc_pack (
	input  u4b_enc_pkg::codes_t codes,
	output u4b_enc_pkg::pack_t  words
);

	logic [9:0]  sq_idx;
	logic [11:0] tv;
	logic [17:0] tvs;

	// callsign word: (g5 * 24 + g6) * 1068 + altitude code
	assign sq_idx = 10'(codes.g5) * 10'd24 + 10'(codes.g6);
	assign words.val = 20'(sq_idx) * 20'(u4b_enc_pkg::AltCodes) + 20'(codes.alt_code);

	// grid word: temperature, voltage, speed, then gps-valid and standard bits
	assign tv = 12'(codes.tcode) * 12'd40 + 12'(codes.vcode);
	assign tvs = 18'(tv) * 18'd42 + 18'(codes.scode);
	assign words.w = {tvs, 2'b11};

endmodule

// ----- hw/rtl/u4b_enc_recip.sv -----
module u4b_enc_recip (
	input  u4b_enc_pkg::pack_t words,
	output u4b_enc_pkg::quot_t quot
);

	logic [u4b_enc_pkg::ProdW-1:0] pv1, pv2, pv3;
	logic [u4b_enc_pkg::ProdW-1:0] pw1, pw2, pw3, pw4;

	// callsign word by 26, 26^2, 26^3
	assign pv1 = u4b_enc_pkg::ProdW'(words.val) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulV1);
	assign pv2 = u4b_enc_pkg::ProdW'(words.val) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulV2);
	assign pv3 = u4b_enc_pkg::ProdW'(words.val) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulV3);

	// grid word by 19, 190, 1900, 34200
	assign pw1 = u4b_enc_pkg::ProdW'(words.w) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulW1);
	assign pw2 = u4b_enc_pkg::ProdW'(words.w) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulW2);
	assign pw3 = u4b_enc_pkg::ProdW'(words.w) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulW3);
	assign pw4 = u4b_enc_pkg::ProdW'(words.w) * u4b_enc_pkg::ProdW'(u4b_enc_pkg::MulW4);

	assign quot.val = words.val;
	assign quot.w = words.w;
	assign quot.vq1 = pv1[u4b_enc_pkg::ShV1 +: 15];
	assign quot.vq2 = pv2[u4b_enc_pkg::ShV2 +: 10];
	assign quot.vq3 = pv3[u4b_enc_pkg::ShV3 +: 6];
	assign quot.wq1 = pw1[u4b_enc_pkg::ShW1 +: 15];
	assign quot.wq2 = pw2[u4b_enc_pkg::ShW2 +: 12];
	assign quot.wq3 = pw3[u4b_enc_pkg::ShW3 +: 9];
	assign quot.wq4 = pw4[u4b_enc_pkg::ShW4 +: 5];

endmodule

// ----- hw/rtl/u4b_enc_digits.sv -----
module u4b_enc_digits (
	input  u4b_enc_pkg::quot_t   quot,
	output u4b_enc_pkg::digits_t digits
);

	logic [19:0] c6_full;
	logic [14:0] c5_full;
	logic [9:0]  c4_full;
	logic [5:0]  c2;
	logic [19:0] p_full;
	logic [14:0] d4_full;
	logic [11:0] d3_full;
	logic [8:0]  l2_full;

	// callsign digits as remainders between neighboring quotients
	assign c6_full = quot.val - 20'(quot.vq1) * 20'd26;
	assign c5_full = quot.vq1 - 15'(quot.vq2) * 15'd26;
	assign c4_full = quot.vq2 - 10'(quot.vq3) * 10'd26;
	assign c2 = quot.vq3;

	// grid digits and power index the same way
	assign p_full = quot.w - 20'(quot.wq1) * 20'd19;
	assign d4_full = quot.wq1 - 15'(quot.wq2) * 15'd10;
	assign d3_full = quot.wq2 - 12'(quot.wq3) * 12'd10;
	assign l2_full = quot.wq3 - 9'(quot.wq4) * 9'd18;

	// base 36 for the second callsign character
	assign digits.call_char_2 = (c2 < 6'd10) ? (u4b_enc_pkg::DigitBase7 + 7'(c2)) :
		(u4b_enc_pkg::LetterBase + 7'(c2 - 6'd10));
	assign digits.call_char_4 = u4b_enc_pkg::LetterBase + 7'(c4_full[4:0]);
	assign digits.call_char_5 = u4b_enc_pkg::LetterBase + 7'(c5_full[4:0]);
	assign digits.call_char_6 = u4b_enc_pkg::LetterBase + 7'(c6_full[4:0]);
	assign digits.grid_char_1 = u4b_enc_pkg::LetterBase + 7'(quot.wq4);
	assign digits.grid_char_2 = u4b_enc_pkg::LetterBase + 7'(l2_full[4:0]);
	assign digits.grid_char_3 = u4b_enc_pkg::DigitBase6 + 6'(d3_full[3:0]);
	assign digits.grid_char_4 = u4b_enc_pkg::DigitBase6 + 6'(d4_full[3:0]);
	assign digits.power_dbm = u4b_enc_pkg::power_level(p_full[4:0]);

endmodule

// ----- hw/rtl/u4b_standard_telemetry_encoder.sv -----
// channel    dir  width  contents
// snapshot   in   75     subsquare letters, altitude, temperature, voltage, speed
// message    out  76     six callsign chars, four grid chars, power in dbm
// cfg        in   2+8    register index, character to write
//
// one request per cycle sustained while the message side is ready; a snapshot
// passes the input, codes, packed words, quotients and characters registers.
// the reciprocal multipliers of the quotient stage and the small constant
// multiplies around them are each closed by its own register.
// reset clears the stage valid bits and loads '0' into both channel characters.
// a stall holds each full stage with no empty stage after it; bubbles fill in.
module u4b_standard_telemetry_encoder (
	input  logic                  clk,
	input  logic                  arst_n,
	u4b_enc_snap_if.sink          snapshot,
	u4b_enc_msg_if.source         message,
	u4b_enc_cfg_if.sink           cfg
);

	logic                 chan_first_q;
	logic [7:0]           first_char_q;
	logic [7:0]           third_char_q;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
	u4b_enc_pkg::raw_t    raw_s1, raw_in;
	u4b_enc_pkg::codes_t  codes_s2, codes_d;
	u4b_enc_pkg::pack_t   words_s3, words_d;
	u4b_enc_pkg::quot_t   quot_s4, quot_d;
	u4b_enc_pkg::digits_t res_s5, res_d;

	// configuration registers, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_char_q <= u4b_enc_pkg::ChanCharReset;
			third_char_q <= u4b_enc_pkg::ChanCharReset;
			chan_first_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				u4b_enc_pkg::CfgFirstChar: begin
					first_char_q <= cfg.data;
					chan_first_q <= 1'b1;
				end
				u4b_enc_pkg::CfgThirdChar: third_char_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage k can take a new entry when empty or when its successor can
	assign rdy5 = !valid_s5 || message.ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign snapshot.ready = rdy1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= snapshot.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// input capture
	assign raw_in.subsquare_letter_a = snapshot.subsquare_letter_a;
	assign raw_in.subsquare_letter_b = snapshot.subsquare_letter_b;
	assign raw_in.altitude_meters = snapshot.altitude_meters;
	assign raw_in.temp_tenths = snapshot.temp_tenths;
	assign raw_in.volt_hundredths = snapshot.volt_hundredths;
	assign raw_in.speed_knots = snapshot.speed_knots;

	u4b_enc_codes u_codes (.raw(raw_s1), .codes(codes_d));
	u4b_enc_pack u_pack (.codes(codes_s2), .words(words_d));
	u4b_enc_recip u_recip (.words(words_s3), .quot(quot_d));
	u4b_enc_digits u_digits (.quot(quot_s4), .digits(res_d));

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy1) raw_s1 <= raw_in;
		if (rdy2) codes_s2 <= codes_d;
		if (rdy3) words_s3 <= words_d;
		if (rdy4) quot_s4 <= quot_d;
		if (rdy5) res_s5 <= res_d;
	end

	// message outputs
	assign message.valid = valid_s5;
	assign message.call_char_1 = first_char_q;
	assign message.call_char_2 = res_s5.call_char_2;
	assign message.call_char_3 = third_char_q;
	assign message.call_char_4 = res_s5.call_char_4;
	assign message.call_char_5 = res_s5.call_char_5;
	assign message.call_char_6 = res_s5.call_char_6;
	assign message.grid_char_1 = res_s5.grid_char_1;
	assign message.grid_char_2 = res_s5.grid_char_2;
	assign message.grid_char_3 = res_s5.grid_char_3;
	assign message.grid_char_4 = res_s5.grid_char_4;
	assign message.power_dbm = res_s5.power_dbm;

	// a taken snapshot lands in the input stage
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		snapshot.valid && snapshot.ready |=> valid_s1)
		else $error("accepted snapshot not captured");

	// a stalled message keeps the stage behind it full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		message.valid && !message.ready && valid_s4 |=> message.valid && valid_s4)
		else $error("pipeline dropped an entry under stall");

	// base 26 letters stay within A..Z
	a_letters: assert property (@(posedge clk) disable iff (!arst_n)
		message.valid |-> message.call_char_4 >= 7'd65 && message.call_char_4 <= 7'd90 &&
			message.call_char_5 >= 7'd65 && message.call_char_5 <= 7'd90 &&
			message.call_char_6 >= 7'd65 && message.call_char_6 <= 7'd90)
		else $error("callsign letter out of range");

	// grid digits and power level stay legal
	a_grid: assert property (@(posedge clk) disable iff (!arst_n)
		message.valid |-> message.grid_char_1 <= 7'd82 && message.grid_char_2 <= 7'd82 &&
			message.grid_char_3 >= 6'd48 && message.grid_char_3 <= 6'd57 &&
			message.grid_char_4 >= 6'd48 && message.grid_char_4 <= 6'd57 &&
			message.power_dbm <= 6'd60)
		else $error("grid or power out of range");

	// first channel character follows its register once written
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		chan_first_q && $stable(first_char_q) |-> message.call_char_1 == first_char_q)
		else $error("callsign character one not from register");

endmodule

// ----- sim/u4b_standard_telemetry_encoder_tb.sv -----
`timescale 1ns / 1ps

module u4b_standard_telemetry_encoder_tb;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 20;
	localparam int ItemsPerPhase = 133;
	localparam int NumVectors = 17;
	localparam int MaxPrinted = 100;

	// register indexes the block does not decode
	localparam logic [u4b_enc_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
	localparam logic [u4b_enc_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

	// one wspr message as seen on the output channel
	typedef struct packed {
		logic [7:0] call_char_1;
		logic [6:0] call_char_2;
		logic [7:0] call_char_3;
		logic [6:0] call_char_4;
		logic [6:0] call_char_5;
		logic [6:0] call_char_6;
		logic [6:0] grid_char_1;
		logic [6:0] grid_char_2;
		logic [5:0] grid_char_3;
		logic [5:0] grid_char_4;
		logic [5:0] power_dbm;
	} msg_t;

	// directed snapshot with an optional hand-worked message
	typedef struct packed {
		u4b_enc_pkg::raw_t snap;
		logic typed;
		msg_t want;
	} snap_vector_t;

	// messages worked out by hand, both channel characters at reset
	// all fields zero or only bad letters: letters as A, 0 c, voltage on its floor
	localparam msg_t MsgQuiet = '{8'd48, 7'd48, 8'd48, 7'd65, 7'd65, 7'd65,
		7'd74, 7'd81, 6'd54, 6'd49, 6'd13};
	// every field saturated high
	localparam msg_t MsgTop = '{8'd48, 7'd90, 8'd48, 7'd65, 7'd65, 7'd72,
		7'd82, 7'd75, 6'd53, 6'd52, 6'd43};
	// temperature on its floor, voltage exactly at its floor
	localparam msg_t MsgCold = '{8'd48, 7'd48, 8'd48, 7'd65, 7'd65, 7'd65,
		7'd65, 7'd66, 6'd55, 6'd55, 6'd0};

	localparam snap_vector_t SnapVectors [NumVectors] = '{
		'{'{8'd0, 8'd0, 20'd0, 15'sd0, 14'd0, 10'd0}, 1'b1, MsgQuiet},
		'{'{"@", "Y", 20'd0, 15'sd0, 14'd0, 10'd0}, 1'b1, MsgQuiet},
		'{'{8'hFF, "[", 20'd0, 15'sd0, 14'd0, 10'd0}, 1'b1, MsgQuiet},
		'{'{"X", "X", 20'd999999, 15'sd9999, 14'd9999, 10'd999}, 1'b1, MsgTop},
		'{'{"A", "A", 20'd0, -15'sd9999, 14'd300, 10'd0}, 1'b1, MsgCold},
		'{'{"X", "A", 20'd21339, 15'sd0, 14'd400, 10'd10}, 1'b0, '0},
		'{'{"A", "X", 20'd21340, 15'sd100, 14'd350, 10'd20}, 1'b0, '0},
		'{'{"M", "N", 20'd21360, -15'sd100, 14'd450, 10'd30}, 1'b0, '0},
		'{'{"A", "B", 20'hFFFFF, 15'sh3FFF, 14'h3FFF, 10'h3FF}, 1'b0, '0},
		'{'{"W", "C", 20'd19, -15'sd16384, 14'd0, 10'd40}, 1'b0, '0},
		'{'{"B", "V", 20'd20, -15'sd501, 14'd299, 10'd81}, 1'b0, '0},
		'{'{"C", "U", 20'd39, -15'sd499, 14'd301, 10'd82}, 1'b0, '0},
		'{'{"D", "T", 20'd40, -15'sd5, 14'd302, 10'd83}, 1'b0, '0},
		'{'{"E", "S", 20'd12345, -15'sd15, 14'd303, 10'd1}, 1'b0, '0},
		'{'{"F", "R", 20'd5000, 15'sd389, 14'd495, 10'd2}, 1'b0, '0},
		'{'{"G", "Q", 20'd777, 15'sd391, 14'd496, 10'd80}, 1'b0, '0},
		'{'{"H", "P", 20'd21341, 15'sd390, 14'd497, 10'd3}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	u4b_enc_snap_if snap_ch ();
	u4b_enc_msg_if  msg_ch ();
	u4b_enc_cfg_if  cfg_ch ();

	u4b_standard_telemetry_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.snapshot (snap_ch),
		.message  (msg_ch),
		.cfg      (cfg_ch)
	);

	logic [7:0] chan_first;
	logic [7:0] chan_third;
	logic no_idle = 1'b0;
	msg_t pending_messages [$];
	int unsigned cycle_count = 0;
	int mismatches = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MaxPrinted)
			$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// subsquare letter to its 0..23 digit, anything outside A..X is A
	function automatic int letter_digit(input logic [7:0] c);
		if (c < u4b_enc_pkg::AsciiA || c > u4b_enc_pkg::AsciiX)
			return 0;
		return int'(c - u4b_enc_pkg::AsciiA);
	endfunction

	// pack one snapshot into callsign, grid and power
	function automatic msg_t encode_snapshot(input u4b_enc_pkg::raw_t s);
		msg_t m;
		int alt;
		int val;
		int t;
		int tcode;
		int v;
		int vcode;
		int spd;
		int w;
		int pidx;
		int d;
		// first packing: subsquare and altitude into the callsign
		alt = int'(s.altitude_meters) / 20;
		if (alt > int'(u4b_enc_pkg::AltMax))
			alt = int'(u4b_enc_pkg::AltMax);
		val = (letter_digit(s.subsquare_letter_a) * 24 + letter_digit(s.subsquare_letter_b))
			* int'(u4b_enc_pkg::AltCodes) + alt;
		m.call_char_6 = 7'(65 + val % 26);
		val = val / 26;
		m.call_char_5 = 7'(65 + val % 26);
		val = val / 26;
		m.call_char_4 = 7'(65 + val % 26);
		val = val / 26;
		d = val % 36;
		m.call_char_2 = (d < 10) ? 7'(48 + d) : 7'(55 + d);
		m.call_char_1 = chan_first;
		m.call_char_3 = chan_third;
		// second packing: temperature, voltage, speed and two flag bits
		t = $signed(s.temp_tenths);
		if (t < int'(u4b_enc_pkg::TempMinTenths))
			t = int'(u4b_enc_pkg::TempMinTenths);
		else if (t > int'(u4b_enc_pkg::TempMaxTenths))
			t = int'(u4b_enc_pkg::TempMaxTenths);
		tcode = t / 10 + 50;
		v = int'(s.volt_hundredths);
		if (v > int'(u4b_enc_pkg::VoltMax))
			v = int'(u4b_enc_pkg::VoltMax);
		else if (v < int'(u4b_enc_pkg::VoltMin))
			v = int'(u4b_enc_pkg::VoltMin);
		vcode = ((v - int'(u4b_enc_pkg::VoltMin) + 2) / 5 + 20) % 40;
		spd = (int'(s.speed_knots) + 1) / 2;
		if (spd > int'(u4b_enc_pkg::SpeedMax))
			spd = int'(u4b_enc_pkg::SpeedMax);
		w = (((tcode * 40 + vcode) * 42 + spd) * 2 + 1) * 2 + 1;
		// legal power levels step 0, 3, 7 within each decade
		pidx = w % 19;
		w = w / 19;
		m.power_dbm = 6'((pidx / 3) * 10 + ((pidx % 3 == 0) ? 0 : ((pidx % 3 == 1) ? 3 : 7)));
		m.grid_char_4 = 6'(48 + w % 10);
		w = w / 10;
		m.grid_char_3 = 6'(48 + w % 10);
		w = w / 10;
		m.grid_char_2 = 7'(65 + w % 18);
		w = w / 18;
		m.grid_char_1 = 7'(65 + w % 18);
		return m;
	endfunction

	// mostly plausible telemetry, with full-width noise on every field
	function automatic u4b_enc_pkg::raw_t random_snapshot();
		u4b_enc_pkg::raw_t s;
		int t;
		s.subsquare_letter_a = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(65, 88))
			: 8'($urandom);
		s.subsquare_letter_b = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(65, 88))
			: 8'($urandom);
		case ($urandom_range(0, 3))
			0: s.altitude_meters = 20'($urandom_range(0, 2000));
			1: s.altitude_meters = 20'($urandom_range(0, 999999));
			2: s.altitude_meters = 20'($urandom_range(21300, 21400));
			default: s.altitude_meters = 20'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: t = int'($urandom_range(0, 1000)) - 500;
			1: t = int'($urandom_range(0, 40)) - 520;
			2: t = int'($urandom_range(0, 19998)) - 9999;
			default: t = int'($urandom);
		endcase
		s.temp_tenths = 15'(t);
		case ($urandom_range(0, 3))
			0: s.volt_hundredths = 14'($urandom_range(280, 520));
			1: s.volt_hundredths = 14'($urandom_range(0, 9999));
			2: s.volt_hundredths = 14'($urandom_range(290, 310));
			default: s.volt_hundredths = 14'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: s.speed_knots = 10'($urandom_range(0, 100));
			1: s.speed_knots = 10'($urandom_range(75, 90));
			default: s.speed_knots = 10'($urandom);
		endcase
		return s;
	endfunction

	// one snapshot request; valid stays up for a following request
	task automatic send_snapshot(input u4b_enc_pkg::raw_t s, input msg_t want);
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			snap_ch.valid <= 1'b0;
			@(posedge clk);
		end
		snap_ch.valid <= 1'b1;
		snap_ch.subsquare_letter_a <= s.subsquare_letter_a;
		snap_ch.subsquare_letter_b <= s.subsquare_letter_b;
		snap_ch.altitude_meters <= s.altitude_meters;
		snap_ch.temp_tenths <= s.temp_tenths;
		snap_ch.volt_hundredths <= s.volt_hundredths;
		snap_ch.speed_knots <= s.speed_knots;
		do @(posedge clk); while (!snap_ch.ready);
		pending_messages.push_back(want);
	endtask

	// register write request; valid stays up for a following write
	task automatic write_register(input logic [u4b_enc_pkg::CfgIdxW-1:0] idx,
		input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == u4b_enc_pkg::CfgFirstChar)
			chan_first = value;
		else if (idx == u4b_enc_pkg::CfgThirdChar)
			chan_third = value;
	endtask

	// hold off the sender until every message is out
	task automatic drain_messages();
		snap_ch.valid <= 1'b0;
		while (pending_messages.size() != 0)
			@(posedge clk);
	endtask

	// receiver stalls
	always @(posedge clk)
		msg_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);

	// message checker
	always @(posedge clk) begin
		msg_t got;
		msg_t want;
		if (arst_n && msg_ch.valid && msg_ch.ready) begin
			got = '{msg_ch.call_char_1, msg_ch.call_char_2, msg_ch.call_char_3,
				msg_ch.call_char_4, msg_ch.call_char_5, msg_ch.call_char_6,
				msg_ch.grid_char_1, msg_ch.grid_char_2, msg_ch.grid_char_3,
				msg_ch.grid_char_4, msg_ch.power_dbm};
			if (pending_messages.size() == 0) begin
				report_mismatch($sformatf("message %h with none pending", got));
			end else begin
				want = pending_messages.pop_front();
				check_field("call_char_1", int'(got.call_char_1), int'(want.call_char_1));
				check_field("call_char_2", int'(got.call_char_2), int'(want.call_char_2));
				check_field("call_char_3", int'(got.call_char_3), int'(want.call_char_3));
				check_field("call_char_4", int'(got.call_char_4), int'(want.call_char_4));
				check_field("call_char_5", int'(got.call_char_5), int'(want.call_char_5));
				check_field("call_char_6", int'(got.call_char_6), int'(want.call_char_6));
				check_field("grid_char_1", int'(got.grid_char_1), int'(want.grid_char_1));
				check_field("grid_char_2", int'(got.grid_char_2), int'(want.grid_char_2));
				check_field("grid_char_3", int'(got.grid_char_3), int'(want.grid_char_3));
				check_field("grid_char_4", int'(got.grid_char_4), int'(want.grid_char_4));
				check_field("power_dbm", int'(got.power_dbm), int'(want.power_dbm));
			end
		end
	end

	initial begin
		u4b_enc_pkg::raw_t s;
		logic [7:0] first;
		logic [7:0] third;
		arst_n = 1'b0;
		chan_first = u4b_enc_pkg::ChanCharReset;
		chan_third = u4b_enc_pkg::ChanCharReset;
		snap_ch.valid = 1'b0;
		snap_ch.subsquare_letter_a = '0;
		snap_ch.subsquare_letter_b = '0;
		snap_ch.altitude_meters = '0;
		snap_ch.temp_tenths = '0;
		snap_ch.volt_hundredths = '0;
		snap_ch.speed_knots = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		msg_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed snapshots with the channel characters at reset
		for (int i = 0; i < NumVectors; i++)
			send_snapshot(SnapVectors[i].snap, SnapVectors[i].typed ? SnapVectors[i].want
				: encode_snapshot(SnapVectors[i].snap));
		drain_messages();

		// random snapshots under several channel settings, extremes first
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					first = 8'hFF;
					third = 8'h00;
				end
				1: begin
					first = 8'h00;
					third = 8'hFF;
				end
				2: begin
					first = "Q";
					third = "7";
				end
				default: begin
					first = 8'($urandom);
					third = 8'($urandom);
				end
			endcase
			write_register(u4b_enc_pkg::CfgFirstChar, first);
			write_register(u4b_enc_pkg::CfgThirdChar, third);
			// writes to undecoded indexes must leave both characters alone
			if (ph == 1) begin
				write_register(CfgSpareLo, 8'($urandom));
				write_register(CfgSpareHi, 8'($urandom));
			end
			cfg_ch.valid <= 1'b0;
			// one phase runs back to back on both sides
			no_idle <= (ph == 2);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				s = random_snapshot();
				send_snapshot(s, encode_snapshot(s));
			end
			drain_messages();
		end

		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
